// File: design/mcs_pkg.sv
// Shared types, constants and update functions of the multi-checksum byte stream.
// Used by every module of the block; depends on nothing.
package mcs_pkg;

   localparam logic [16:0] AdlerMod   = 17'd65521;
   localparam logic [8:0]  Fletch255  = 9'd255;
   localparam logic [15:0] CrcPoly    = 16'h1021;
   localparam logic [15:0] CrcInit    = 16'hFFFF;
   localparam logic [15:0] AdlerLowInit = 16'd1;
   localparam logic [15:0] CountMax   = 16'hFFFF;
   localparam int          RspDataWidth = 136;

   typedef struct packed {
      logic       last_byte;
      logic [7:0] data_byte;
   } mcs_item_type;

   typedef struct packed {
      logic [15:0] block_length;
      logic [15:0] wrap_sum;
      logic [7:0]  xor_byte;
      logic [15:0] fletcher_seeded;
      logic [15:0] fletcher_mod256;
      logic [15:0] fletcher_mod255;
      logic [15:0] crc_value;
      logic [31:0] adler_sum;
   } mcs_result_type;

   function automatic logic [15:0] adler_add(input logic [15:0] x, input logic [15:0] y);
      logic [16:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= AdlerMod) begin
         s = s - AdlerMod;
      end
      return s[15:0];
   endfunction

   function automatic logic [7:0] add_mod255(input logic [7:0] x, input logic [7:0] y);
      logic [8:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= Fletch255) begin
         s = s - Fletch255;
      end
      return s[7:0];
   endfunction

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CrcPoly;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// File: design/multi_checksum_byte_stream_top.sv
// Multi-checksum byte stream: Adler-32, CRC-16, three Fletcher-16 forms, XOR, sum, length.
// The last word of a block waits in the input register; then its result is registered.
// Throughput: one word per cycle unless stalled; the input register and update set it.
// A waiting result stalls input only when the next last word reaches the update stage.
// Synchronous active-high reset empties both registers and restores every start value.
// Depends on mcs_pkg, mcs_input_stage, mcs_checksum_core and mcs_output_stage.
module multi_checksum_byte_stream_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,  // data_byte
   input  logic                               req_tlast,  // last_byte
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // Fields from bit 0 up: adler_sum, crc_value, fletcher_mod255, fletcher_mod256,
   // fletcher_seeded, xor_byte, wrap_sum, block_length.
   output logic [mcs_pkg::RspDataWidth-1:0]   rsp_tdata
);
   import mcs_pkg::*;

   mcs_item_type   in_item;
   mcs_item_type   held_item;
   mcs_result_type core_result;
   mcs_result_type out_result;
   logic           held_valid;
   logic           advance;
   logic           step;
   logic           accept;

   assign in_item.data_byte = req_tdata;
   assign in_item.last_byte = req_tlast;

   assign advance    = !(held_item.last_byte && rsp_tvalid && !rsp_tready);
   assign step       = held_valid && advance;
   assign req_tready = !held_valid || advance;
   assign accept     = req_tvalid && req_tready;

   mcs_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .advance    (step),
      .item       (in_item),
      .held_valid (held_valid),
      .held_item  (held_item)
   );

   mcs_checksum_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (held_item),
      .result (core_result)
   );

   mcs_output_stage u_output (
      .clock      (clock),
      .reset      (reset),
      .load       (step && held_item.last_byte),
      .result     (core_result),
      .out_ready  (rsp_tready),
      .out_valid  (rsp_tvalid),
      .out_result (out_result)
   );

   assign rsp_tdata = out_result;

endmodule

// File: design/mcs_input_stage.sv
// Input register of the multi-checksum byte stream: holds one accepted word.
// Depends on mcs_pkg.
module mcs_input_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic                  advance,
   input  mcs_pkg::mcs_item_type item,
   output logic                  held_valid,
   output mcs_pkg::mcs_item_type held_item
);
   import mcs_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   mcs_item_type item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item;
      end
   end

   assign held_valid = valid_ff;
   assign held_item  = item_ff;

endmodule

// File: design/mcs_checksum_core.sv
// Running checksum state and its one-word update for every checksum kind.
// Depends on mcs_pkg.
module mcs_checksum_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  mcs_pkg::mcs_item_type   item,
   output mcs_pkg::mcs_result_type result
);
   import mcs_pkg::*;

   logic [15:0] adler_low_ff, adler_low_in;
   logic [15:0] adler_high_ff, adler_high_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  m255_first_ff, m255_first_in;
   logic [7:0]  m255_second_ff, m255_second_in;
   logic [7:0]  m256_first_ff, m256_first_in;
   logic [7:0]  m256_second_ff, m256_second_in;
   logic [7:0]  seed_first_ff, seed_first_in;
   logic [7:0]  seed_second_ff, seed_second_in;
   logic [7:0]  xor_ff, xor_in;
   logic [15:0] sum_ff, sum_in;
   logic [15:0] count_ff, count_in;
   logic        start_ff;
   logic [7:0]  b;
   logic [7:0]  seed_base;

   always_comb begin
      b              = item.data_byte;
      adler_low_in   = adler_add(adler_low_ff, {8'h00, b});
      adler_high_in  = adler_add(adler_high_ff, adler_low_in);
      crc_in         = crc_byte(crc_ff, b);
      m255_first_in  = add_mod255(m255_first_ff, b);
      m255_second_in = add_mod255(m255_second_ff, m255_first_in);
      m256_first_in  = m256_first_ff + b;
      m256_second_in = m256_second_ff + m256_first_in;
      seed_base      = start_ff ? b : seed_first_ff;
      seed_first_in  = seed_base + b;
      seed_second_in = seed_second_ff + seed_first_in;
      xor_in         = xor_ff ^ b;
      sum_in         = sum_ff + {8'h00, b};
      count_in       = (count_ff == CountMax) ? count_ff : count_ff + 16'd1;
   end

   always_comb begin
      result.adler_sum       = {adler_high_in, adler_low_in};
      result.crc_value       = crc_in;
      result.fletcher_mod255 = {m255_second_in, m255_first_in};
      result.fletcher_mod256 = {m256_second_in, m256_first_in};
      result.fletcher_seeded = {seed_second_in, seed_first_in};
      result.xor_byte        = xor_in;
      result.wrap_sum        = sum_in;
      result.block_length    = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && item.last_byte)) begin
         adler_low_ff   <= AdlerLowInit;
         adler_high_ff  <= '0;
         crc_ff         <= CrcInit;
         m255_first_ff  <= '0;
         m255_second_ff <= '0;
         m256_first_ff  <= '0;
         m256_second_ff <= '0;
         seed_first_ff  <= '0;
         seed_second_ff <= '0;
         xor_ff         <= '0;
         sum_ff         <= '0;
         count_ff       <= '0;
         start_ff       <= 1'b1;
      end else if (step) begin
         adler_low_ff   <= adler_low_in;
         adler_high_ff  <= adler_high_in;
         crc_ff         <= crc_in;
         m255_first_ff  <= m255_first_in;
         m255_second_ff <= m255_second_in;
         m256_first_ff  <= m256_first_in;
         m256_second_ff <= m256_second_in;
         seed_first_ff  <= seed_first_in;
         seed_second_ff <= seed_second_in;
         xor_ff         <= xor_in;
         sum_ff         <= sum_in;
         count_ff       <= count_in;
         start_ff       <= 1'b0;
      end
   end

endmodule

// File: design/mcs_output_stage.sv
// Result register of the multi-checksum byte stream with its valid flag.
// Depends on mcs_pkg.
module mcs_output_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  mcs_pkg::mcs_result_type result,
   input  logic                    out_ready,
   output logic                    out_valid,
   output mcs_pkg::mcs_result_type out_result
);
   import mcs_pkg::*;

   logic           valid_ff;
   logic           valid_in;
   mcs_result_type result_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

// File: tb/multi_checksum_byte_stream_top_test.sv
`timescale 1ns / 100ps
// Self-checking bench for multi_checksum_byte_stream_top: sends byte blocks and predicts every
// checksum word, compared field by field as results arrive. Depends on mcs_pkg and the RTL.
module multi_checksum_byte_stream_top_test;
   import mcs_pkg::*;

   localparam int unsigned AdlerModulus  = 65521;
   localparam int unsigned FletcherMod   = 255;
   localparam logic [15:0] CrcPolynomial = 16'h1021;
   localparam logic [15:0] LengthCap     = 16'hFFFF;
   localparam int unsigned RandomWords   = 1000;
   localparam int unsigned LongBlockLen  = 600;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [7:0]              req_tdata  = '0;  // data_byte
   logic                    req_tlast  = 1'b0;  // last_byte
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   // Fields from bit 0 up: adler_sum, crc_value, fletcher_mod255, fletcher_mod256,
   // fletcher_seeded, xor_byte, wrap_sum, block_length.
   logic [RspDataWidth-1:0] rsp_tdata;

   mcs_result_type pending_sums[$];
   int unsigned    error_count = 0;
   int unsigned    words_sent = 0;
   bit             sender_idles = 1'b0;
   bit             receiver_stalls = 1'b0;
   int unsigned    burst_left = 0;
   logic [15:0]    stall_pattern = 16'hFFFF;
   int unsigned    pattern_age = 0;

   int unsigned adler_a;
   int unsigned adler_b;
   logic [15:0] crc_acc;
   int unsigned f255_a;
   int unsigned f255_b;
   logic [7:0]  f256_a;
   logic [7:0]  f256_b;
   logic [7:0]  seeded_a;
   logic [7:0]  seeded_b;
   logic [7:0]  parity_acc;
   logic [15:0] byte_total;
   logic [15:0] length_acc;
   bit          block_fresh;

   multi_checksum_byte_stream_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void clear_sums();
      adler_a     = 1;
      adler_b     = 0;
      crc_acc     = 16'hFFFF;
      f255_a      = 0;
      f255_b      = 0;
      f256_a      = '0;
      f256_b      = '0;
      seeded_a    = '0;
      seeded_b    = '0;
      parity_acc  = '0;
      byte_total  = '0;
      length_acc  = '0;
      block_fresh = 1'b1;
   endfunction

   function automatic void absorb_byte(input logic [7:0] b, input logic last);
      mcs_result_type sums;
      logic [15:0]    c;
      int             i;
      adler_a = (adler_a + b) % AdlerModulus;
      adler_b = (adler_b + adler_a) % AdlerModulus;
      c = crc_acc ^ {b, 8'h00};
      for (i = 0; i < 8; i++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CrcPolynomial) : {c[14:0], 1'b0};
      end
      crc_acc = c;
      f255_a = (f255_a + b) % FletcherMod;
      f255_b = (f255_b + f255_a) % FletcherMod;
      f256_a = f256_a + b;
      f256_b = f256_b + f256_a;
      // The first byte of a block seeds the A sum, so it is counted twice.
      if (block_fresh) begin
         seeded_a = b;
      end
      seeded_a = seeded_a + b;
      seeded_b = seeded_b + seeded_a;
      parity_acc = parity_acc ^ b;
      byte_total = byte_total + b;
      if (length_acc != LengthCap) begin
         length_acc = length_acc + 16'd1;
      end
      block_fresh = 1'b0;
      if (last) begin
         sums.adler_sum       = {adler_b[15:0], adler_a[15:0]};
         sums.crc_value       = crc_acc;
         sums.fletcher_mod255 = {f255_b[7:0], f255_a[7:0]};
         sums.fletcher_mod256 = {f256_b, f256_a};
         sums.fletcher_seeded = {seeded_b, seeded_a};
         sums.xor_byte        = parity_acc;
         sums.wrap_sum        = byte_total;
         sums.block_length    = length_acc;
         pending_sums.push_back(sums);
         clear_sums();
      end
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      mcs_result_type got;
      mcs_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_sums.size() == 0) begin
            $error("result word with no block pending: %0h", rsp_tdata);
            error_count++;
         end else begin
            want = pending_sums.pop_front();
            check_field("adler_sum", want.adler_sum, got.adler_sum);
            check_field("crc_value", want.crc_value, got.crc_value);
            check_field("fletcher_mod255", want.fletcher_mod255, got.fletcher_mod255);
            check_field("fletcher_mod256", want.fletcher_mod256, got.fletcher_mod256);
            check_field("fletcher_seeded", want.fletcher_seeded, got.fletcher_seeded);
            check_field("xor_byte", want.xor_byte, got.xor_byte);
            check_field("wrap_sum", want.wrap_sum, got.wrap_sum);
            check_field("block_length", want.block_length, got.block_length);
         end
      end
   end

   // The receiver walks a rotating mask that is redrawn whenever a random countdown expires.
   always @(posedge clock) begin
      pattern_age   <= (pattern_age == 0) ? $urandom_range(16, 160) : pattern_age - 1;
      stall_pattern <= (pattern_age == 0) ? 16'($urandom)
                                          : {stall_pattern[0], stall_pattern[15:1]};
      rsp_tready    <= !receiver_stalls || stall_pattern[0];
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (sender_idles) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      absorb_byte(b, last);
      words_sent++;
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_sums.size() != 0);
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic test_directed_blocks();
      sender_idles    = 1'b0;
      receiver_stalls = 1'b0;
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_byte(8'hAA, 1'b0);
      send_byte(8'h55, 1'b1);
      send_byte(8'h01, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'hFE, 1'b1);
      for (int k = 0; k < 14; k++) begin
         send_byte(8'hFF, k == 13);
      end
   endtask

   task automatic test_random_blocks();
      int unsigned len;
      int unsigned block_index;
      int unsigned start_count;
      block_index = 0;
      start_count = words_sent;
      while (words_sent - start_count < RandomWords) begin
         if ($urandom_range(0, 7) == 0) begin
            sender_idles    = $urandom_range(0, 3) != 0;
            receiver_stalls = $urandom_range(0, 3) != 0;
         end
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: len = $urandom_range(1, 8);
            6, 7, 8:          len = $urandom_range(9, 64);
            default:          len = $urandom_range(65, 400);
         endcase
         if (block_index == 10 || $urandom_range(0, 40) == 0) begin
            wait_for_results();
         end
         for (int k = 0; k < len; k++) begin
            send_byte(pick_byte(), k == len - 1);
         end
         block_index++;
      end
   endtask

   task automatic test_long_block();
      sender_idles    = 1'b1;
      receiver_stalls = 1'b1;
      for (int k = 0; k < LongBlockLen; k++) begin
         send_byte(pick_byte(), k == LongBlockLen - 1);
      end
      send_byte(pick_byte(), 1'b1);
   endtask

   initial begin
      int unsigned spare;
      clear_sums();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed_blocks();
      test_random_blocks();
      test_long_block();
      req_tvalid <= 1'b0;
      spare = 0;
      while (pending_sums.size() != 0 && spare < 20000) begin
         @(posedge clock);
         spare++;
      end
      if (pending_sums.size() != 0) begin
         $error("%0d expected result words never arrived", pending_sums.size());
         error_count++;
      end
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("[multi_checksum_byte_stream_top] OK");
      end else begin
         $display("[multi_checksum_byte_stream_top] ERROR");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("[multi_checksum_byte_stream_top] ERROR");
      $finish;
   end

endmodule

// File: filelist.f
design/mcs_pkg.sv
design/mcs_input_stage.sv
design/mcs_checksum_core.sv
design/mcs_output_stage.sv
design/multi_checksum_byte_stream_top.sv
tb/multi_checksum_byte_stream_top_test.sv
